// ===== rtl/core/itre_pkg.sv =====
// Shared types and constants for the ICMP timestamp reply engine.
package itre_pkg;

  localparam int unsigned MSG_BYTES = 20;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned IDX_W     = 5;
  localparam int unsigned FRAME_W   = MSG_BYTES * 8;
  localparam int unsigned SUM_A_W   = 19;
  localparam int unsigned SUM_B_W   = 18;
  localparam int unsigned CSUM_W    = 16;

  localparam logic [7:0] REQUEST_TYPE = 8'd13;
  localparam logic [7:0] REPLY_TYPE   = 8'd14;
  localparam logic [7:0] TS_CODE      = 8'd0;

  localparam logic [CNT_W-1:0] COUNT_MAX  = 5'd31;
  localparam logic [CNT_W-1:0] MIN_LENGTH = 5'd20;
  localparam logic [IDX_W-1:0] LAST_IDX   = 5'd19;

  // Byte positions captured from the request.
  localparam logic [CNT_W-1:0] POS_TYPE      = 5'd0;
  localparam logic [CNT_W-1:0] POS_CODE      = 5'd1;
  localparam logic [CNT_W-1:0] POS_IDENT_HI  = 5'd4;
  localparam logic [CNT_W-1:0] POS_IDENT_LO  = 5'd5;
  localparam logic [CNT_W-1:0] POS_SEQ_HI    = 5'd6;
  localparam logic [CNT_W-1:0] POS_SEQ_LO    = 5'd7;
  localparam logic [CNT_W-1:0] POS_ORIG_FST  = 5'd8;
  localparam logic [CNT_W-1:0] POS_ORIG_LST  = 5'd11;

  // One finished request waiting to be turned into results.
  typedef struct packed {
    logic               ok;
    logic [15:0]        ident;
    logic [15:0]        seq;
    logic [31:0]        orig;
    logic [31:0]        rx;
    logic [31:0]        tx;
    logic [SUM_A_W-1:0] sum_a;
    logic [SUM_B_W-1:0] sum_b;
  } itre_job_t;

endpackage

// ===== rtl/core/itre_checksum.sv =====
// One's-complement combine and fold of the two partial sums into the reply checksum.
module itre_checksum
  import itre_pkg::*;
(
  input  logic [SUM_A_W-1:0] sum_a,
  input  logic [SUM_B_W-1:0] sum_b,
  output logic [CSUM_W-1:0]  csum
);

  logic [SUM_A_W:0]  total;
  logic [CSUM_W:0]   fold1;
  logic [CSUM_W-1:0] fold2;

  // Two end-around-carry folds bring the 20-bit total into 16 bits.
  always_comb begin
    total = {1'b0, sum_a} + {{(SUM_A_W - SUM_B_W + 1){1'b0}}, sum_b};
    fold1 = {1'b0, total[CSUM_W-1:0]}
          + {{(2*CSUM_W - SUM_A_W){1'b0}}, total[SUM_A_W:CSUM_W]};
    fold2 = fold1[CSUM_W-1:0] + {{(CSUM_W-1){1'b0}}, fold1[CSUM_W]};
    csum  = ~fold2;
  end

endmodule

// ===== rtl/core/icmp_timestamp_reply_engine_core.sv =====
// Top level of the ICMP timestamp reply engine: capture, job register and reply serializer.
//
// The slave stream carries one request byte per transfer: tdata holds the byte
// and the receive and transmit times, tlast marks the final byte of a request.
// Only the times given with the final byte are used.
// The master stream returns results one byte per transfer: tdata is the reply
// byte, tlast marks the final result of a request and tuser says whether the
// request was accepted. A good request (at least 20 bytes, type 13, code 0)
// yields a 20-byte timestamp reply; any other request yields a single result
// with tuser low, tdata zero and tlast high.
// The final request byte is captured into the job register, which then
// loads the output register once it is free; the checksum fold is done on
// the way into the output register.
// Throughput: one request byte per cycle and one result per cycle. A reply
// occupies the output register for all of its 20 results; one further finished
// request can wait in the job register meanwhile, and the slave side stalls
// only when that register is full and the output cannot take it.
// When the receiver stalls, the current result holds and the job register
// fills. Synchronous reset clears the captured header fields, the byte
// count and both valid flags, so no result is pending after reset.
module icmp_timestamp_reply_engine_core
  import itre_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // request_byte[7:0], receive_time[39:8], transmit_time[71:40]
  input  logic        s_axis_tlast,  // end_of_request
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // reply_byte[7:0]
  output logic        m_axis_tlast,  // reply_last
  output logic        m_axis_tuser   // accepted
);

  // Request capture state.
  logic [CNT_W-1:0] byte_count;
  logic [7:0]       seen_type;
  logic [7:0]       seen_code;
  logic [15:0]      echo_identifier;
  logic [15:0]      echo_sequence;
  logic [31:0]      echo_originate;

  // Job register between capture and the serializer.
  logic      job_valid;
  itre_job_t job;
  itre_job_t job_next;

  // Output register: the reply frame shifts out from its top byte.
  logic               out_valid;
  logic               out_acc;
  logic [IDX_W-1:0]   out_idx;
  logic [FRAME_W-1:0] frame;

  logic [7:0]       req_byte;
  logic [31:0]      rx_time;
  logic [31:0]      tx_time;
  logic             in_fire;
  logic             out_fire;
  logic             out_done;
  logic             out_load;
  logic [CNT_W-1:0] count_next;
  logic [CSUM_W-1:0] csum;

  assign req_byte = s_axis_tdata[7:0];
  assign rx_time  = s_axis_tdata[39:8];
  assign tx_time  = s_axis_tdata[71:40];

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = frame[FRAME_W-1 -: 8];
  assign m_axis_tuser  = out_acc;
  assign m_axis_tlast  = !out_acc || (out_idx == LAST_IDX);

  assign out_fire = out_valid && m_axis_tready;
  assign out_done = out_fire && m_axis_tlast;
  assign out_load = job_valid && (!out_valid || out_done);

  // The slave side is open whenever the job register is free or drains this cycle.
  assign s_axis_tready = !job_valid || out_load;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign count_next = (byte_count < COUNT_MAX) ? byte_count + 5'd1 : byte_count;

  // On the final byte the header has already been captured whenever the request
  // is long enough to be answered, so the job is built from the stored fields.
  always_comb begin
    job_next.ok    = (count_next >= MIN_LENGTH) && (seen_type == REQUEST_TYPE)
                     && (seen_code == TS_CODE);
    job_next.ident = echo_identifier;
    job_next.seq   = echo_sequence;
    job_next.orig  = echo_originate;
    job_next.rx    = rx_time;
    job_next.tx    = tx_time;
    // Reply header word (type 14, code 0) plus the echoed words.
    job_next.sum_a = SUM_A_W'({REPLY_TYPE, TS_CODE})
                   + SUM_A_W'(echo_identifier) + SUM_A_W'(echo_sequence)
                   + SUM_A_W'(echo_originate[31:16]) + SUM_A_W'(echo_originate[15:0]);
    // The two timestamps given with the final byte.
    job_next.sum_b = SUM_B_W'(rx_time[31:16]) + SUM_B_W'(rx_time[15:0])
                   + SUM_B_W'(tx_time[31:16]) + SUM_B_W'(tx_time[15:0]);
  end

  itre_checksum u_checksum (
    .sum_a (job.sum_a),
    .sum_b (job.sum_b),
    .csum  (csum)
  );

  // Capture of the request header; everything returns to zero after a final byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      seen_type       <= '0;
      seen_code       <= '0;
      echo_identifier <= '0;
      echo_sequence   <= '0;
      echo_originate  <= '0;
    end else if (in_fire) begin
      if (s_axis_tlast) begin
        byte_count      <= '0;
        seen_type       <= '0;
        seen_code       <= '0;
        echo_identifier <= '0;
        echo_sequence   <= '0;
        echo_originate  <= '0;
      end else begin
        byte_count <= count_next;
        if (byte_count == POS_TYPE) begin
          seen_type <= req_byte;
        end
        if (byte_count == POS_CODE) begin
          seen_code <= req_byte;
        end
        if (byte_count == POS_IDENT_HI || byte_count == POS_IDENT_LO) begin
          echo_identifier <= {echo_identifier[7:0], req_byte};
        end
        if (byte_count == POS_SEQ_HI || byte_count == POS_SEQ_LO) begin
          echo_sequence <= {echo_sequence[7:0], req_byte};
        end
        if (byte_count >= POS_ORIG_FST && byte_count <= POS_ORIG_LST) begin
          echo_originate <= {echo_originate[23:0], req_byte};
        end
      end
    end
  end

  // Job register.
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (in_fire && s_axis_tlast) begin
      job_valid <= 1'b1;
    end else if (out_load) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && s_axis_tlast) begin
      job <= job_next;
    end
  end

  // Output register and byte serializer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_acc   <= 1'b0;
      out_idx   <= '0;
    end else if (out_load) begin
      out_valid <= 1'b1;
      out_acc   <= job.ok;
      out_idx   <= '0;
    end else if (out_done) begin
      out_valid <= 1'b0;
    end else if (out_fire) begin
      out_idx <= out_idx + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (job.ok) begin
        frame <= {REPLY_TYPE, TS_CODE, csum, job.ident, job.seq, job.orig, job.rx, job.tx};
      end else begin
        frame <= '0;
      end
    end else if (out_fire) begin
      frame <= {frame[FRAME_W-9:0], 8'h00};
    end
  end

  // A rejection is always a single, final result.
  a_reject_single : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 8'h00))
    else $error("rejection result is not a single zero byte");

  // The first byte of an accepted reply is the reply type.
  a_first_type : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_acc && (out_idx == '0) |-> m_axis_tdata == REPLY_TYPE)
    else $error("reply does not start with the reply type");

  // A reply burst runs without gaps once a byte has been taken.
  a_burst_cont : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("reply burst broke off before its last byte");

  // The serializer index stays inside the 20-byte frame.
  a_idx_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_idx <= LAST_IDX)
    else $error("reply byte index beyond the frame");

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the ICMP timestamp reply engine: byte stimulus, reply prediction and checking.
`timescale 1ns / 1ps

module tb_top;
  import itre_pkg::*;

  localparam int ITEM_TARGET  = 220;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;

  // One result as it leaves the master side.
  typedef struct packed {
    logic [7:0] reply_byte;
    logic       reply_last;
    logic       accepted;
  } ts_result_t;

  // One ICMP message to send. Field order for table rows: len, msg_type,
  // msg_code, ident, seq, orig, rx, tx, fill, fill_random, reject_typed.
  typedef struct packed {
    logic [5:0]  len;
    logic [7:0]  msg_type;
    logic [7:0]  msg_code;
    logic [15:0] ident;
    logic [15:0] seq;
    logic [31:0] orig;
    logic [31:0] rx;
    logic [31:0] tx;
    logic [7:0]  fill;
    logic        fill_random;
    logic        reject_typed;
  } ts_message_t;

  localparam ts_result_t REJECT_RESULT = '{8'h00, 1'b1, 1'b0};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;  // request_byte[7:0], receive_time[39:8], transmit_time[71:40]
  logic        s_axis_tlast = 1'b0;  // end_of_request
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;  // reply_byte[7:0]
  logic        m_axis_tlast;  // reply_last
  logic        m_axis_tuser;  // accepted

  icmp_timestamp_reply_engine_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the engine's capture state, cleared after every final byte.
  logic [4:0]  seen_bytes = '0;
  logic [7:0]  got_type   = '0;
  logic [7:0]  got_code   = '0;
  logic [15:0] got_ident  = '0;
  logic [15:0] got_seq    = '0;
  logic [31:0] got_orig   = '0;

  ts_result_t forecast [MSG_BYTES];
  ts_result_t pending_results [$];
  int         fail_count   = 0;
  int         bytes_sent   = 0;
  bit         quiet        = 1'b0;
  bit         random_phase = 1'b0;

  // Mostly back to back, often a short pause, now and then a long one.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Absorbs one accepted byte; on a final byte fills forecast and returns
  // the number of results it yields.
  task automatic predict_reply(input logic [7:0] b, input logic last,
                               input logic [31:0] rx, input logic [31:0] tx,
                               output int n);
    logic [FRAME_W-1:0] frame;
    logic [31:0]        sum;
    int                 i;
    n = 0;
    case (seen_bytes)
      POS_TYPE:                   got_type  = b;
      POS_CODE:                   got_code  = b;
      POS_IDENT_HI, POS_IDENT_LO: got_ident = {got_ident[7:0], b};
      POS_SEQ_HI, POS_SEQ_LO:     got_seq   = {got_seq[7:0], b};
      default: begin
        if (seen_bytes >= POS_ORIG_FST && seen_bytes <= POS_ORIG_LST)
          got_orig = {got_orig[23:0], b};
      end
    endcase
    if (seen_bytes < COUNT_MAX) seen_bytes = seen_bytes + 5'd1;
    if (last) begin
      if (seen_bytes < MIN_LENGTH || got_type != REQUEST_TYPE || got_code != TS_CODE) begin
        forecast[0] = REJECT_RESULT;
        n = 1;
      end else begin
        frame = {REPLY_TYPE, TS_CODE, 16'h0000, got_ident, got_seq, got_orig, rx, tx};
        // One's-complement sum over the ten 16-bit words, checksum word zero.
        sum = '0;
        for (i = 0; i < MSG_BYTES / 2; i++) begin
          sum = sum + 32'(frame[FRAME_W-1-16*i -: 16]);
          sum = 32'(sum[15:0]) + 32'(sum[31:16]);
        end
        sum = 32'(sum[15:0]) + 32'(sum[31:16]);
        frame[FRAME_W-17 -: 16] = ~sum[15:0];
        for (i = 0; i < MSG_BYTES; i++) begin
          forecast[i].reply_byte = frame[FRAME_W-1-8*i -: 8];
          forecast[i].reply_last = (i == MSG_BYTES - 1);
          forecast[i].accepted   = 1'b1;
        end
        n = MSG_BYTES;
      end
      seen_bytes = '0;
      got_type   = '0;
      got_code   = '0;
      got_ident  = '0;
      got_seq    = '0;
      got_orig   = '0;
    end
  endtask

  // Sends one message byte by byte; each byte is one transfer on the slave side.
  task automatic send_message(input ts_message_t m);
    logic [7:0]  b;
    logic [31:0] rx;
    logic [31:0] tx;
    logic        last;
    int          n;
    int          p;
    int          g;
    int          i;
    for (p = 0; p < int'(m.len); p++) begin
      if (m.fill_random) b = 8'($urandom_range(0, 255));
      else b = m.fill;
      case (p)
        POS_TYPE:     b = m.msg_type;
        POS_CODE:     b = m.msg_code;
        POS_IDENT_HI: b = m.ident[15:8];
        POS_IDENT_LO: b = m.ident[7:0];
        POS_SEQ_HI:   b = m.seq[15:8];
        POS_SEQ_LO:   b = m.seq[7:0];
        default: begin
          if (p >= int'(POS_ORIG_FST) && p <= int'(POS_ORIG_LST))
            b = m.orig[8*(int'(POS_ORIG_LST)-p) +: 8];
        end
      endcase
      last = (p == int'(m.len) - 1);
      // Times on earlier bytes are ignored, so they carry noise.
      rx = last ? m.rx : $urandom;
      tx = last ? m.tx : $urandom;
      g = idle_gap();
      if (g > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (g) @(posedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= {tx, rx, b};
      s_axis_tlast  <= last;
      do @(posedge clk); while (!s_axis_tready);
      predict_reply(b, last, rx, tx, n);
      if (m.reject_typed && n != 0) begin
        pending_results.push_back(REJECT_RESULT);
      end else begin
        for (i = 0; i < n; i++) pending_results.push_back(forecast[i]);
      end
    end
    bytes_sent += int'(m.len);
  endtask

  // Mostly well-formed messages with random content, the rest broken.
  function automatic ts_message_t random_message();
    ts_message_t m;
    int          r;
    r             = $urandom_range(0, 99);
    m.len         = 6'(MSG_BYTES);
    m.msg_type    = REQUEST_TYPE;
    m.msg_code    = TS_CODE;
    m.ident       = 16'($urandom);
    m.seq         = 16'($urandom);
    m.orig        = $urandom;
    m.rx          = $urandom;
    m.tx          = $urandom;
    m.fill        = '0;
    m.fill_random = 1'b1;
    m.reject_typed = 1'b0;
    if (r < 55) begin
      m.len = 6'(MSG_BYTES);
    end else if (r < 70) begin
      // Long enough to drive the byte count into saturation now and then.
      m.len = 6'($urandom_range(MSG_BYTES + 1, 40));
    end else if (r < 78) begin
      m.len = 6'($urandom_range(1, MSG_BYTES - 1));
    end else if (r < 86) begin
      m.len      = 6'($urandom_range(MSG_BYTES, 24));
      m.msg_type = 8'($urandom_range(0, 255));
      if (m.msg_type == REQUEST_TYPE) m.msg_type = REPLY_TYPE;
    end else if (r < 94) begin
      m.len      = 6'($urandom_range(MSG_BYTES, 24));
      m.msg_code = 8'($urandom_range(1, 255));
    end else begin
      m.len      = 6'($urandom_range(1, 40));
      m.msg_type = 8'($urandom_range(0, 255));
      m.msg_code = 8'($urandom_range(0, 255));
    end
    return m;
  endfunction

  initial begin : stimulus
    ts_message_t directed_msgs [3];
    int          k;
    // Lone final byte right after reset, with a bad type.
    directed_msgs[0] = '{6'd1, 8'hFF, TS_CODE, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0,
                         8'h00, 1'b0, 1'b1};
    // Correct type and code but far too short.
    directed_msgs[1] = '{6'd2, REQUEST_TYPE, TS_CODE, 16'h0000, 16'h0000, 32'h0,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b1};
    // Minimal valid message with extreme field values.
    directed_msgs[2] = '{6'd20, REQUEST_TYPE, TS_CODE, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF,
                         32'hFFFF_FFFF, 32'h0000_0000, 8'hFF, 1'b0, 1'b0};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    for (k = 0; k < 3; k++) send_message(directed_msgs[k]);

    random_phase = 1'b1;
    k = 0;
    while (bytes_sent < ITEM_TARGET) begin
      // A few messages in the middle run with no idling on either side.
      quiet = (k >= 4 && k < 7);
      send_message(random_message());
      k++;
    end
    quiet = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Receiver: random ready pattern plus one long hold-off once random
  // traffic starts, so the job register fills and the slave side stalls.
  initial begin : sink
    bit hold_done;
    int g;
    hold_done = 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (random_phase && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      g = idle_gap();
      if (g > 0) begin
        m_axis_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  // Every accepted result must match the oldest outstanding prediction.
  always @(posedge clk) begin
    ts_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: reply_byte=%0h reply_last=%0b accepted=%0b",
               m_axis_tdata, m_axis_tlast, m_axis_tuser);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata !== want.reply_byte) begin
          $error("reply_byte: expected %0h, got %0h", want.reply_byte, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tlast !== want.reply_last) begin
          $error("reply_last: expected %0b, got %0b", want.reply_last, m_axis_tlast);
          fail_count++;
        end
        if (m_axis_tuser !== want.accepted) begin
          $error("accepted: expected %0b, got %0b", want.accepted, m_axis_tuser);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
